// File: rtl/lpi_pkg.sv
// ----------------------------------------------------------------------------
// lpi_pkg
// Widths, stage payload types and saturation helper for the line/plane
// intersection pipeline.
// ----------------------------------------------------------------------------
package lpi_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FRAC_BITS   = 16;

   // difference of two coordinates
   localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
   // coordinate times difference
   localparam int PROD_WIDTH  = COORD_WIDTH + DIFF_WIDTH;
   // sum of three products
   localparam int SUM_WIDTH   = PROD_WIDTH + 2;
   // point component before clamping
   localparam int EXT_WIDTH   = PROD_WIDTH + 1;
   // quotient magnitude bits that can land inside the coordinate range
   localparam int QUO_WIDTH   = COORD_WIDTH + 1;
   localparam int NUM_WIDTH   = SUM_WIDTH + FRAC_BITS;
   localparam int INIT_WIDTH  = NUM_WIDTH - QUO_WIDTH;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;

   typedef struct packed {
      logic [SUM_WIDTH-1:0]                  rem;
      logic [SUM_WIDTH-1:0]                  dmag;
      logic [QUO_WIDTH-1:0]                  nlow;
      logic [QUO_WIDTH-1:0]                  quo;
      logic                                  ovf;
      logic                                  negq;
      logic                                  zero;
      logic [2:0][DIFF_WIDTH-1:0]            dir;
      logic [2:0][COORD_WIDTH-1:0]           start;
   } div_stage_type;

   typedef struct packed {
      logic      sat;
      coord_type value;
   } clamp_type;

   function automatic clamp_type clamp_coord(input logic signed [EXT_WIDTH-1:0] x);
      clamp_type r;
      logic      fits;
      fits = (x[EXT_WIDTH-1:COORD_WIDTH-1] == '0) || (x[EXT_WIDTH-1:COORD_WIDTH-1] == '1);
      if (fits) begin
         r.sat   = 1'b0;
         r.value = x[COORD_WIDTH-1:0];
      end else begin
         r.sat   = 1'b1;
         r.value = x[EXT_WIDTH-1] ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                  : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end
      return r;
   endfunction

endpackage

// File: rtl/lpi_req_if.sv
// ----------------------------------------------------------------------------
// lpi_req_if
// Request channel: plane and line description, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpi_req_if import lpi_pkg::*;;
   logic      valid;
   logic      ready;
   coord_type normal_x;
   coord_type normal_y;
   coord_type normal_z;
   coord_type plane_x;
   coord_type plane_y;
   coord_type plane_z;
   coord_type start_x;
   coord_type start_y;
   coord_type start_z;
   coord_type end_x;
   coord_type end_y;
   coord_type end_z;

   modport source (output valid, normal_x, normal_y, normal_z, plane_x, plane_y, plane_z,
                   start_x, start_y, start_z, end_x, end_y, end_z, input ready);
   modport sink   (input valid, normal_x, normal_y, normal_z, plane_x, plane_y, plane_z,
                   start_x, start_y, start_z, end_x, end_y, end_z, output ready);
endinterface

// File: rtl/lpi_rsp_if.sv
// ----------------------------------------------------------------------------
// lpi_rsp_if
// Response channel: crossing parameter and point, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lpi_rsp_if import lpi_pkg::*;;
   logic      valid;
   logic      ready;
   logic      hit;
   coord_type param_t;
   coord_type cross_x;
   coord_type cross_y;
   coord_type cross_z;
   logic      saturated;

   modport source (output valid, hit, param_t, cross_x, cross_y, cross_z, saturated,
                   input ready);
   modport sink   (input valid, hit, param_t, cross_x, cross_y, cross_z, saturated,
                   output ready);
endinterface

// File: rtl/lpi_div_pipe.sv
// ----------------------------------------------------------------------------
// lpi_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with per-stage
// valid bits and bubble-collapsing flow control.
// ----------------------------------------------------------------------------
module lpi_div_pipe import lpi_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  div_stage_type in_data,
   output logic          out_valid,
   input  logic          out_ready,
   output div_stage_type out_data
);

   logic          valid_ff [QUO_WIDTH];
   div_stage_type stage_ff [QUO_WIDTH];
   logic          adv      [QUO_WIDTH];

   genvar k;
   for (k = 0; k < QUO_WIDTH; k++) begin : g_step
      logic                 src_valid;
      div_stage_type        src;
      div_stage_type        stage_in;
      logic [SUM_WIDTH:0]   shifted;
      logic [SUM_WIDTH:0]   diff;
      logic                 ge;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src       = in_data;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src       = stage_ff[k-1];
      end

      if (k == QUO_WIDTH - 1) begin : g_last
         assign adv[k] = !valid_ff[k] || out_ready;
      end else begin : g_mid
         assign adv[k] = !valid_ff[k] || adv[k+1];
      end

      always_comb begin
         shifted       = {src.rem, src.nlow[QUO_WIDTH-1]};
         diff          = shifted - {1'b0, src.dmag};
         ge            = !diff[SUM_WIDTH];
         stage_in      = src;
         stage_in.rem  = ge ? diff[SUM_WIDTH-1:0] : shifted[SUM_WIDTH-1:0];
         stage_in.quo  = {src.quo[QUO_WIDTH-2:0], ge};
         stage_in.nlow = {src.nlow[QUO_WIDTH-2:0], 1'b0};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (adv[k]) begin
            valid_ff[k] <= src_valid;
         end
         if (adv[k]) begin
            stage_ff[k] <= stage_in;
         end
      end
   end

   assign in_ready  = adv[0];
   assign out_valid = valid_ff[QUO_WIDTH-1];
   assign out_data  = stage_ff[QUO_WIDTH-1];

endmodule

// File: rtl/line_plane_intersection_core.sv
// ----------------------------------------------------------------------------
// line_plane_intersection_core
// Line/plane crossing in signed fixed point: t = n.(p-s)/n.d and s + t*d,
// saturated to the coordinate format.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  req_chan  in         normal, plane point, line start, line end
//  rsp_chan  out        hit, param_t, cross_x/y/z, saturated
//
//  one transaction per cycle sustained while rsp_chan is ready; 5 setup stages,
//  one divider stage per quotient bit, 3 stages for t, product and point
//  reset clears every stage valid bit; data registers are not reset
//  a stall stops only the stages that hold data, so bubbles are squeezed out
// ----------------------------------------------------------------------------
module line_plane_intersection_core import lpi_pkg::*; (
   input logic      clock,
   input logic      reset,
   lpi_req_if.sink  req_chan,
   lpi_rsp_if.source rsp_chan
);

   // stage a: differences
   logic                               a_valid_ff;
   logic signed [2:0][COORD_WIDTH-1:0] a_n_ff;
   logic signed [2:0][DIFF_WIDTH-1:0]  a_ps_ff, a_d_ff, a_ps_in, a_d_in;
   logic [2:0][COORD_WIDTH-1:0]        a_s_ff;
   coord_type                          in_n [3], in_p [3], in_s [3], in_e [3];

   // stage b: products
   logic                               b_valid_ff;
   logic signed [PROD_WIDTH-1:0]       b_pn_ff [3], b_pd_ff [3];
   logic [2:0][DIFF_WIDTH-1:0]         b_d_ff;
   logic [2:0][COORD_WIDTH-1:0]        b_s_ff;

   // stage c: sums
   logic                               c_valid_ff;
   logic signed [SUM_WIDTH-1:0]        c_num_ff, c_den_ff, c_num_in, c_den_in;
   logic [2:0][DIFF_WIDTH-1:0]         c_d_ff;
   logic [2:0][COORD_WIDTH-1:0]        c_s_ff;

   // stage d: magnitudes
   logic                               d_valid_ff, d_negq_ff, d_zero_ff;
   logic [SUM_WIDTH-1:0]               d_nmag_ff, d_dmag_ff;
   logic [2:0][DIFF_WIDTH-1:0]         d_d_ff;
   logic [2:0][COORD_WIDTH-1:0]        d_s_ff;

   // stage e: divider setup
   logic                               e_valid_ff;
   div_stage_type                      e_ff, e_in;
   logic [NUM_WIDTH-1:0]               e_num;

   logic                               div_in_ready, div_out_valid;
   div_stage_type                      div_out;

   // stage f: clamped t
   logic                               f_valid_ff, f_sat_ff, f_zero_ff, f_sat_in;
   coord_type                          f_t_ff, f_t_in;
   logic [2:0][DIFF_WIDTH-1:0]         f_d_ff;
   logic [2:0][COORD_WIDTH-1:0]        f_s_ff;
   logic [QUO_WIDTH-1:0]               f_neg;

   // stage g: t*d
   logic                               g_valid_ff, g_sat_ff, g_zero_ff;
   coord_type                          g_t_ff;
   logic signed [PROD_WIDTH-1:0]       g_prod_ff [3];
   logic [2:0][COORD_WIDTH-1:0]        g_s_ff;

   // stage h: output register
   logic                               h_valid_ff, h_hit_ff, h_sat_ff, h_sat_in;
   coord_type                          h_t_ff, h_t_in;
   coord_type                          h_cross_ff [3], h_cross_in [3];
   clamp_type                          h_clamp [3];

   logic adv_a, adv_b, adv_c, adv_d, adv_e, adv_f, adv_g, adv_h;

   assign adv_h = !h_valid_ff || rsp_chan.ready;
   assign adv_g = !g_valid_ff || adv_h;
   assign adv_f = !f_valid_ff || adv_g;
   assign adv_e = !e_valid_ff || div_in_ready;
   assign adv_d = !d_valid_ff || adv_e;
   assign adv_c = !c_valid_ff || adv_d;
   assign adv_b = !b_valid_ff || adv_c;
   assign adv_a = !a_valid_ff || adv_b;
   assign req_chan.ready = adv_a;

   assign in_n = '{req_chan.normal_x, req_chan.normal_y, req_chan.normal_z};
   assign in_p = '{req_chan.plane_x, req_chan.plane_y, req_chan.plane_z};
   assign in_s = '{req_chan.start_x, req_chan.start_y, req_chan.start_z};
   assign in_e = '{req_chan.end_x, req_chan.end_y, req_chan.end_z};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         a_ps_in[i] = $signed({in_p[i][COORD_WIDTH-1], in_p[i]})
                    - $signed({in_s[i][COORD_WIDTH-1], in_s[i]});
         a_d_in[i]  = $signed({in_e[i][COORD_WIDTH-1], in_e[i]})
                    - $signed({in_s[i][COORD_WIDTH-1], in_s[i]});
      end
   end

   always_comb begin
      c_num_in = '0;
      c_den_in = '0;
      for (int i = 0; i < 3; i++) begin
         c_num_in = c_num_in + {{2{b_pn_ff[i][PROD_WIDTH-1]}}, b_pn_ff[i]};
         c_den_in = c_den_in + {{2{b_pd_ff[i][PROD_WIDTH-1]}}, b_pd_ff[i]};
      end
   end

   always_comb begin
      e_num       = {d_nmag_ff, {FRAC_BITS{1'b0}}};
      e_in.rem    = {{(SUM_WIDTH-INIT_WIDTH){1'b0}}, e_num[NUM_WIDTH-1:QUO_WIDTH]};
      e_in.dmag   = d_dmag_ff;
      e_in.nlow   = e_num[QUO_WIDTH-1:0];
      e_in.quo    = '0;
      // quotient would need more bits than the divider produces
      e_in.ovf    = e_in.rem >= d_dmag_ff;
      e_in.negq   = d_negq_ff;
      e_in.zero   = d_zero_ff;
      e_in.dir    = d_d_ff;
      e_in.start  = d_s_ff;
   end

   always_comb begin
      f_neg    = QUO_WIDTH'(0) - div_out.quo;
      f_sat_in = 1'b0;
      f_t_in   = f_neg[COORD_WIDTH-1:0];
      if (div_out.zero) begin
         f_t_in = '0;
      end else if (div_out.ovf) begin
         f_sat_in = 1'b1;
         f_t_in   = div_out.negq ? {1'b1, {(COORD_WIDTH-1){1'b0}}}
                                 : {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else if (!div_out.negq) begin
         if (div_out.quo[QUO_WIDTH-1] || div_out.quo[COORD_WIDTH-1]) begin
            f_sat_in = 1'b1;
            f_t_in   = {1'b0, {(COORD_WIDTH-1){1'b1}}};
         end else begin
            f_t_in   = div_out.quo[COORD_WIDTH-1:0];
         end
      end else if (div_out.quo > (QUO_WIDTH'(1) << (COORD_WIDTH-1))) begin
         f_sat_in = 1'b1;
         f_t_in   = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end
   end

   always_comb begin
      h_sat_in = g_sat_ff;
      h_t_in   = g_t_ff;
      for (int i = 0; i < 3; i++) begin
         h_clamp[i] = clamp_coord($signed({g_prod_ff[i][PROD_WIDTH-1],
                                           g_prod_ff[i] >>> FRAC_BITS})
                                  + $signed({{(EXT_WIDTH-COORD_WIDTH){g_s_ff[i][COORD_WIDTH-1]}},
                                             g_s_ff[i]}));
         h_cross_in[i] = h_clamp[i].value;
         h_sat_in      = h_sat_in | h_clamp[i].sat;
      end
      if (g_zero_ff) begin
         h_sat_in   = 1'b0;
         h_t_in     = '0;
         h_cross_in = '{default: '0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         f_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
      end else begin
         if (adv_a) a_valid_ff <= req_chan.valid;
         if (adv_b) b_valid_ff <= a_valid_ff;
         if (adv_c) c_valid_ff <= b_valid_ff;
         if (adv_d) d_valid_ff <= c_valid_ff;
         if (adv_e) e_valid_ff <= d_valid_ff;
         if (adv_f) f_valid_ff <= div_out_valid;
         if (adv_g) g_valid_ff <= f_valid_ff;
         if (adv_h) h_valid_ff <= g_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) begin
         for (int i = 0; i < 3; i++) begin
            a_n_ff[i] <= in_n[i];
            a_s_ff[i] <= in_s[i];
         end
         a_ps_ff <= a_ps_in;
         a_d_ff  <= a_d_in;
      end
      if (adv_b) begin
         for (int i = 0; i < 3; i++) begin
            b_pn_ff[i] <= $signed(a_n_ff[i]) * $signed(a_ps_ff[i]);
            b_pd_ff[i] <= $signed(a_n_ff[i]) * $signed(a_d_ff[i]);
         end
         b_d_ff <= a_d_ff;
         b_s_ff <= a_s_ff;
      end
      if (adv_c) begin
         c_num_ff <= c_num_in;
         c_den_ff <= c_den_in;
         c_d_ff   <= b_d_ff;
         c_s_ff   <= b_s_ff;
      end
      if (adv_d) begin
         d_negq_ff <= c_num_ff[SUM_WIDTH-1] ^ c_den_ff[SUM_WIDTH-1];
         d_zero_ff <= c_den_ff == '0;
         d_nmag_ff <= c_num_ff[SUM_WIDTH-1] ? SUM_WIDTH'(-c_num_ff) : c_num_ff;
         d_dmag_ff <= c_den_ff[SUM_WIDTH-1] ? SUM_WIDTH'(-c_den_ff) : c_den_ff;
         d_d_ff    <= c_d_ff;
         d_s_ff    <= c_s_ff;
      end
      if (adv_e) begin
         e_ff <= e_in;
      end
      if (adv_f) begin
         f_t_ff    <= f_t_in;
         f_sat_ff  <= f_sat_in;
         f_zero_ff <= div_out.zero;
         f_d_ff    <= div_out.dir;
         f_s_ff    <= div_out.start;
      end
      if (adv_g) begin
         for (int i = 0; i < 3; i++) begin
            g_prod_ff[i] <= f_t_ff * $signed(f_d_ff[i]);
         end
         g_t_ff    <= f_t_ff;
         g_sat_ff  <= f_sat_ff;
         g_zero_ff <= f_zero_ff;
         g_s_ff    <= f_s_ff;
      end
      if (adv_h) begin
         h_hit_ff   <= !g_zero_ff;
         h_t_ff     <= h_t_in;
         h_sat_ff   <= h_sat_in;
         h_cross_ff <= h_cross_in;
      end
   end

   lpi_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid_ff),
      .in_ready  (div_in_ready),
      .in_data   (e_ff),
      .out_valid (div_out_valid),
      .out_ready (adv_f),
      .out_data  (div_out)
   );

   assign rsp_chan.valid     = h_valid_ff;
   assign rsp_chan.hit       = h_hit_ff;
   assign rsp_chan.param_t   = h_t_ff;
   assign rsp_chan.cross_x   = h_cross_ff[0];
   assign rsp_chan.cross_y   = h_cross_ff[1];
   assign rsp_chan.cross_z   = h_cross_ff[2];
   assign rsp_chan.saturated = h_sat_ff;

`ifndef SYNTHESIS
   a_miss_is_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.hit |-> rsp_chan.param_t == '0 && !rsp_chan.saturated
         && rsp_chan.cross_x == '0 && rsp_chan.cross_y == '0 && rsp_chan.cross_z == '0)
      else $error("parallel line produced nonzero result");

   a_t_clamp : assert property (@(posedge clock) disable iff (reset)
      f_valid_ff && f_sat_ff |-> f_t_ff == {1'b0, {(COORD_WIDTH-1){1'b1}}}
         || f_t_ff == {1'b1, {(COORD_WIDTH-1){1'b0}}})
      else $error("saturated t is not a range limit");

   a_full_stall : assert property (@(posedge clock) disable iff (reset)
      h_valid_ff && !rsp_chan.ready && g_valid_ff && f_valid_ff && div_out_valid
         && !div_in_ready && e_valid_ff && d_valid_ff && c_valid_ff && b_valid_ff
         && a_valid_ff |-> !req_chan.ready)
      else $error("request taken while pipeline is full");

   a_hold_output : assert property (@(posedge clock) disable iff (reset)
      h_valid_ff && !rsp_chan.ready |=> $stable(h_t_ff) && $stable(h_cross_ff[0])
         && h_valid_ff)
      else $error("stalled response changed");
`endif

endmodule
